### hw/rtl/rclf_pkg.sv
// Package with the shared types, register indexes and reset values of the link failsafe monitor.
`timescale 1ns / 1ps

package rclf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LOSS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LOSS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARMED_RECOV   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISARM_RECOV  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_LIMIT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_CENTRE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_GOOD_BEEP     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_BEEP    = 3'd7;

    localparam logic [9:0]  RST_SHORT_LOSS   = 10'd12;
    localparam logic [9:0]  RST_LONG_LOSS    = 10'd50;
    localparam logic [9:0]  RST_ARMED_RECOV  = 10'd250;
    localparam logic [9:0]  RST_DISARM_RECOV = 10'd100;
    localparam logic [13:0] RST_STICK_LIMIT  = 14'd50;
    localparam logic [11:0] RST_STICK_CENTRE = 12'd1500;
    localparam logic [7:0]  RST_GOOD_BEEP    = 8'd100;
    localparam logic [7:0]  RST_ALARM_BEEP   = 8'd150;

    localparam logic [15:0] LOSS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [9:0]  short_loss_ticks;
        logic [9:0]  long_loss_ticks;
        logic [9:0]  armed_recover_ticks;
        logic [9:0]  disarmed_recover_ticks;
        logic [13:0] stick_motion_limit;
        logic [11:0] stick_centre;
        logic [7:0]  good_beep_ticks;
        logic [7:0]  alarm_beep_ticks;
    } cfg_t;

    // Declared from the highest bit down so that the cast matches the tdata packing.
    typedef struct packed {
        logic        gyro_calibrating;
        logic        rth_switch_on;
        logic [11:0] yaw_pulse;
        logic [11:0] pitch_pulse;
        logic [11:0] roll_pulse;
        logic        armed;
        logic        frame_received;
    } item_t;

    typedef struct packed {
        logic beep_alarm;
        logic beep_link_good;
        logic release_rth;
        logic recovered;
        logic force_safe_controls;
        logic failsafe_active;
        logic immediate_failsafe;
    } result_t;

endpackage

### hw/rtl/rclf_cfg_regs.sv
// Configuration register file of the link failsafe monitor.
`timescale 1ns / 1ps

module rclf_cfg_regs
    import rclf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SHORT_LOSS:   cfg_next.short_loss_ticks       = cfg_wdata[9:0];
                CFG_LONG_LOSS:    cfg_next.long_loss_ticks        = cfg_wdata[9:0];
                CFG_ARMED_RECOV:  cfg_next.armed_recover_ticks    = cfg_wdata[9:0];
                CFG_DISARM_RECOV: cfg_next.disarmed_recover_ticks = cfg_wdata[9:0];
                CFG_STICK_LIMIT:  cfg_next.stick_motion_limit     = cfg_wdata[13:0];
                CFG_STICK_CENTRE: cfg_next.stick_centre           = cfg_wdata[11:0];
                CFG_GOOD_BEEP:    cfg_next.good_beep_ticks        = cfg_wdata[7:0];
                CFG_ALARM_BEEP:   cfg_next.alarm_beep_ticks       = cfg_wdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_loss_ticks       <= RST_SHORT_LOSS;
            cfg_reg.long_loss_ticks        <= RST_LONG_LOSS;
            cfg_reg.armed_recover_ticks    <= RST_ARMED_RECOV;
            cfg_reg.disarmed_recover_ticks <= RST_DISARM_RECOV;
            cfg_reg.stick_motion_limit     <= RST_STICK_LIMIT;
            cfg_reg.stick_centre           <= RST_STICK_CENTRE;
            cfg_reg.good_beep_ticks        <= RST_GOOD_BEEP;
            cfg_reg.alarm_beep_ticks       <= RST_ALARM_BEEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/rclf_tick_engine.sv
// Per-tick failsafe state and the logic that advances it for one beat.
`timescale 1ns / 1ps

module rclf_tick_engine
    import rclf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [15:0] loss_count_reg, loss_count_next;
    logic        fast_flag_reg, fast_flag_next;
    logic        event_flag_reg, event_flag_next;
    logic [9:0]  good_tick_count_reg, good_tick_count_next;
    logic        good_beep_pending_reg, good_beep_pending_next;
    logic        disarmed_done_reg, disarmed_done_next;
    logic [7:0]  beep_tick_count_reg, beep_tick_count_next;

    logic [15:0] loss_now;
    logic [11:0] dev_roll, dev_pitch, dev_yaw;
    logic [13:0] motion;
    logic        run_reached;
    logic        do_reset;

    always_comb begin
        dev_roll  = (item.roll_pulse >= cfg.stick_centre) ? item.roll_pulse - cfg.stick_centre
                                                          : cfg.stick_centre - item.roll_pulse;
        dev_pitch = (item.pitch_pulse >= cfg.stick_centre) ? item.pitch_pulse - cfg.stick_centre
                                                           : cfg.stick_centre - item.pitch_pulse;
        dev_yaw   = (item.yaw_pulse >= cfg.stick_centre) ? item.yaw_pulse - cfg.stick_centre
                                                         : cfg.stick_centre - item.yaw_pulse;
        motion    = {2'b00, dev_roll} + {2'b00, dev_pitch} + {2'b00, dev_yaw};
    end

    always_comb begin
        fast_flag_next         = fast_flag_reg;
        event_flag_next        = event_flag_reg;
        good_tick_count_next   = good_tick_count_reg;
        good_beep_pending_next = good_beep_pending_reg;
        disarmed_done_next     = disarmed_done_reg;
        beep_tick_count_next   = beep_tick_count_reg;
        result                 = '0;
        run_reached            = 1'b0;
        do_reset               = 1'b0;

        loss_now = item.frame_received ? 16'd0 : loss_count_reg;

        if (loss_now > {6'd0, cfg.short_loss_ticks}) begin
            fast_flag_next = 1'b1;
        end

        if (loss_now > {6'd0, cfg.long_loss_ticks}) begin
            event_flag_next            = 1'b1;
            result.force_safe_controls = 1'b1;
        end else if (event_flag_reg) begin
            if (item.armed) begin
                run_reached = good_tick_count_reg >= cfg.armed_recover_ticks;
                if (!run_reached) begin
                    good_tick_count_next = good_tick_count_reg + 10'd1;
                end
                do_reset = run_reached && (motion >= cfg.stick_motion_limit);
            end else if (!disarmed_done_reg) begin
                run_reached = good_tick_count_reg >= cfg.disarmed_recover_ticks;
                if (!run_reached) begin
                    good_tick_count_next = good_tick_count_reg + 10'd1;
                end
                do_reset = run_reached;
            end
            if (do_reset) begin
                fast_flag_next         = 1'b0;
                event_flag_next        = 1'b0;
                result.recovered       = 1'b1;
                result.release_rth     = !item.rth_switch_on;
                good_tick_count_next   = 10'd0;
                beep_tick_count_next   = 8'd0;
                good_beep_pending_next = 1'b1;
            end
            // Every tick of a held event clears the done mark; nothing in the engine sets it.
            disarmed_done_next = 1'b0;
        end

        loss_count_next = (loss_now < LOSS_MAX) ? loss_now + 16'd1 : loss_now;

        if (good_tick_count_next == 10'd0 && !event_flag_next && good_beep_pending_next) begin
            if (beep_tick_count_next >= cfg.good_beep_ticks) begin
                result.beep_link_good  = 1'b1;
                beep_tick_count_next   = 8'd0;
                good_beep_pending_next = 1'b0;
            end else begin
                beep_tick_count_next = beep_tick_count_next + 8'd1;
            end
        end

        if (event_flag_next && !item.gyro_calibrating) begin
            if (beep_tick_count_next >= cfg.alarm_beep_ticks) begin
                result.beep_alarm = 1'b1;
            end else begin
                beep_tick_count_next = beep_tick_count_next + 8'd1;
            end
        end

        result.immediate_failsafe = fast_flag_next;
        result.failsafe_active    = event_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_count_reg        <= 16'd0;
            fast_flag_reg         <= 1'b0;
            event_flag_reg        <= 1'b0;
            good_tick_count_reg   <= 10'd0;
            good_beep_pending_reg <= 1'b0;
            disarmed_done_reg     <= 1'b0;
            beep_tick_count_reg   <= 8'd0;
        end else if (step_en) begin
            loss_count_reg        <= loss_count_next;
            fast_flag_reg         <= fast_flag_next;
            event_flag_reg        <= event_flag_next;
            good_tick_count_reg   <= good_tick_count_next;
            good_beep_pending_reg <= good_beep_pending_next;
            disarmed_done_reg     <= disarmed_done_next;
            beep_tick_count_reg   <= beep_tick_count_next;
        end
    end

endmodule

### hw/rtl/rc_link_failsafe_monitor.sv
// Top level of the radio-link failsafe monitor: beat registers, configuration and tick engine.
//
//  channel   direction  beat contents
//  s_axis    in         one control-loop tick: link, arm and stick state
//  m_axis    out        one result per tick: failsafe flags and beeps
//  cfg       in         register write, index and data, no read-back
//
// A tick beat is taken into an input register, worked combinationally and held
// in an output register, so one beat can be accepted in every cycle unless the
// output is stalled with the input register full.
// A stalled output holds its beat; the input register keeps taking a beat
// whenever it is empty or moves on in the same cycle.
// Reset is synchronous and clears the beat valids, the failsafe state and the
// configuration registers to their defaults.
`timescale 1ns / 1ps

module rc_link_failsafe_monitor
    import rclf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // frame_received, armed, roll_pulse, pitch_pulse, yaw_pulse, rth_switch_on,
    // gyro_calibrating
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // immediate_failsafe, failsafe_active, force_safe_controls, recovered,
    // release_rth, beep_link_good, beep_alarm, one zero pad bit
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t result;
    result_t result_reg;
    logic    step_en;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    rclf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rclf_tick_engine u_tick_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_t'(s_tdata);
        end
        if (step_en) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

endmodule

### bench/testbench.sv
// Self-checking bench for the radio-link failsafe monitor, with a tick predictor and scoreboard.
`timescale 1ns / 1ps

module testbench;
    import rclf_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_RUN     = 20;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    item_t   pending_ticks[$];
    result_t expected_flags[$];
    item_t   offered_tick;

    cfg_t        link_cfg;
    logic [15:0] loss_cnt;
    logic        fast_flag, event_flag, good_beep_pend, disarm_done;
    logic [9:0]  good_ticks;
    logic [7:0]  beep_ticks;

    int gap_pct = 0, stall_pct = 0;
    int gap_left = 0, stall_left = 0, hold_left = 0;
    bit hold_request = 1'b0;
    bit offer_free;
    int quiet_cycles = 0;
    int n_mismatch = 0, n_results = 0, n_ticks = 0, n_settings = 0;
    int n_forced = 0, n_recovered = 0, n_released = 0, n_good_beeps = 0, n_alarms = 0;
    int n_saturated = 0;

    rc_link_failsafe_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [11:0] pulse_offset(logic [11:0] a, logic [11:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic result_t predict_tick(item_t t);
        result_t     r;
        logic        do_clear;
        logic [15:0] motion;
        r = '0;
        do_clear = 1'b0;
        n_ticks++;
        if (t.frame_received) loss_cnt = '0;
        if (loss_cnt > link_cfg.short_loss_ticks) fast_flag = 1'b1;
        if (loss_cnt > link_cfg.long_loss_ticks) begin
            event_flag = 1'b1;
            r.force_safe_controls = 1'b1;
        end else if (event_flag) begin
            if (t.armed) begin
                if (good_ticks >= link_cfg.armed_recover_ticks) begin
                    motion = 16'(pulse_offset(t.roll_pulse, link_cfg.stick_centre))
                           + 16'(pulse_offset(t.pitch_pulse, link_cfg.stick_centre))
                           + 16'(pulse_offset(t.yaw_pulse, link_cfg.stick_centre));
                    if (motion >= link_cfg.stick_motion_limit) do_clear = 1'b1;
                end else begin
                    good_ticks = good_ticks + 10'd1;
                end
            end else if (!disarm_done) begin
                if (good_ticks >= link_cfg.disarmed_recover_ticks) begin
                    disarm_done = 1'b1;
                    do_clear = 1'b1;
                end else begin
                    good_ticks = good_ticks + 10'd1;
                    disarm_done = 1'b0;
                end
            end
            if (do_clear) begin
                fast_flag = 1'b0;
                event_flag = 1'b0;
                r.recovered = 1'b1;
                r.release_rth = !t.rth_switch_on;
                good_ticks = '0;
                beep_ticks = '0;
                good_beep_pend = 1'b1;
                disarm_done = 1'b0;
            end
        end
        if (loss_cnt != LOSS_MAX) loss_cnt = loss_cnt + 16'd1;
        else n_saturated++;
        if (good_ticks == '0 && !event_flag && good_beep_pend) begin
            if (beep_ticks >= link_cfg.good_beep_ticks) begin
                r.beep_link_good = 1'b1;
                beep_ticks = '0;
                good_beep_pend = 1'b0;
            end else begin
                beep_ticks = beep_ticks + 8'd1;
            end
        end
        if (event_flag && !t.gyro_calibrating) begin
            if (beep_ticks >= link_cfg.alarm_beep_ticks) r.beep_alarm = 1'b1;
            else beep_ticks = beep_ticks + 8'd1;
        end
        r.immediate_failsafe = fast_flag;
        r.failsafe_active = event_flag;
        n_forced += r.force_safe_controls;
        n_recovered += r.recovered;
        n_released += r.release_rth;
        n_good_beeps += r.beep_link_good;
        n_alarms += r.beep_alarm;
        return r;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_flags.push_back(predict_tick(offered_tick));
                offer_free = 1'b1;
            end else begin
                offer_free = !s_tvalid;
            end
            if (offer_free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    offered_tick = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= offered_tick;
                    gap_left = pick_gap(gap_pct);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_flag(string field, logic want_bit, logic got_bit);
        if (got_bit !== want_bit) begin
            if (n_mismatch < 10)
                $display("mismatch in result %0d: %s expected %0b got %0b",
                         n_results, field, want_bit, got_bit);
            n_mismatch++;
        end
    endtask

    task automatic check_result(logic [M_TDATA_W-1:0] beat);
        result_t got, want;
        got = result_t'(beat[6:0]);
        if (expected_flags.size() == 0) begin
            if (n_mismatch < 10) $display("result beat %b arrived with no tick outstanding", beat);
            n_mismatch++;
        end else begin
            want = expected_flags.pop_front();
            check_flag("immediate_failsafe", want.immediate_failsafe, got.immediate_failsafe);
            check_flag("failsafe_active", want.failsafe_active, got.failsafe_active);
            check_flag("force_safe_controls", want.force_safe_controls,
                       got.force_safe_controls);
            check_flag("recovered", want.recovered, got.recovered);
            check_flag("release_rth", want.release_rth, got.release_rth);
            check_flag("beep_link_good", want.beep_link_good, got.beep_link_good);
            check_flag("beep_alarm", want.beep_alarm, got.beep_alarm);
            check_flag("pad bit", 1'b0, beat[7]);
        end
        n_results++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap(stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_SHORT_LOSS:   link_cfg.short_loss_ticks = value[9:0];
            CFG_LONG_LOSS:    link_cfg.long_loss_ticks = value[9:0];
            CFG_ARMED_RECOV:  link_cfg.armed_recover_ticks = value[9:0];
            CFG_DISARM_RECOV: link_cfg.disarmed_recover_ticks = value[9:0];
            CFG_STICK_LIMIT:  link_cfg.stick_motion_limit = value;
            CFG_STICK_CENTRE: link_cfg.stick_centre = value[11:0];
            CFG_GOOD_BEEP:    link_cfg.good_beep_ticks = value[7:0];
            CFG_ALARM_BEEP:   link_cfg.alarm_beep_ticks = value[7:0];
            default: ;
        endcase
    endtask

    // Bits above a register's width are filled with noise; the block must drop them.
    task automatic load_settings(cfg_t c);
        write_reg(CFG_SHORT_LOSS, {4'($urandom), c.short_loss_ticks});
        write_reg(CFG_LONG_LOSS, {4'($urandom), c.long_loss_ticks});
        write_reg(CFG_ARMED_RECOV, {4'($urandom), c.armed_recover_ticks});
        write_reg(CFG_DISARM_RECOV, {4'($urandom), c.disarmed_recover_ticks});
        write_reg(CFG_STICK_LIMIT, c.stick_motion_limit);
        write_reg(CFG_STICK_CENTRE, {2'($urandom), c.stick_centre});
        write_reg(CFG_GOOD_BEEP, {6'($urandom), c.good_beep_ticks});
        write_reg(CFG_ALARM_BEEP, {6'($urandom), c.alarm_beep_ticks});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        n_settings++;
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || expected_flags.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    task automatic queue_fixed(logic f, logic a, logic [11:0] r, logic [11:0] p,
                               logic [11:0] y, logic rth, logic g);
        pending_ticks.push_back('{gyro_calibrating: g, rth_switch_on: rth, yaw_pulse: y,
                                  pitch_pulse: p, roll_pulse: r, armed: a,
                                  frame_received: f});
    endtask

    function automatic logic [11:0] near_centre(int spread);
        int v;
        if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 4095));
        v = int'(link_cfg.stick_centre) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        else if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    function automatic item_t make_tick(logic frame, logic arm, int spread);
        item_t t;
        t.frame_received = frame;
        t.armed = arm;
        t.roll_pulse = near_centre(spread);
        t.pitch_pulse = near_centre(spread);
        t.yaw_pulse = near_centre(spread);
        t.rth_switch_on = 1'($urandom_range(0, 1));
        t.gyro_calibrating = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    // A loss burst followed by a run of good ticks, or now and then plain noise.
    task automatic queue_episode();
        int   loss_len, good_len, spread, i;
        logic arm;
        arm = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6))
                pending_ticks.push_back(make_tick(1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1)),
                                                  $urandom_range(0, 2000)));
        end else begin
            loss_len = $urandom_range(0, link_cfg.long_loss_ticks + 3);
            good_len = $urandom_range(1, link_cfg.armed_recover_ticks
                                         + link_cfg.disarmed_recover_ticks + 4);
            spread = $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(0, 400);
            for (i = 0; i < loss_len; i++)
                pending_ticks.push_back(make_tick($urandom_range(0, 14) == 0, arm, spread));
            for (i = 0; i < good_len; i++) begin
                if ($urandom_range(0, 9) == 0) arm = !arm;
                pending_ticks.push_back(make_tick(1'b1, arm, spread));
            end
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    task automatic run_phase(cfg_t c, int n_items, bit hold);
        wait_idle();
        load_settings(c);
        gap_pct = hold ? 5 : pick_pct();
        stall_pct = hold ? 0 : pick_pct();
        while (pending_ticks.size() < n_items) queue_episode();
        if (hold) hold_request = 1'b1;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.short_loss_ticks = 10'($urandom_range(0, 6));
        c.long_loss_ticks = 10'($urandom_range(0, 10));
        c.armed_recover_ticks = 10'($urandom_range(0, 8));
        c.disarmed_recover_ticks = 10'($urandom_range(0, 8));
        c.stick_motion_limit = 14'($urandom_range(0, 300));
        c.stick_centre = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) : 12'd1500;
        c.good_beep_ticks = 8'($urandom_range(0, 8));
        c.alarm_beep_ticks = 8'($urandom_range(0, 8));
        return c;
    endfunction

    initial begin
        cfg_t c;
        int   i;
        link_cfg = '{RST_SHORT_LOSS, RST_LONG_LOSS, RST_ARMED_RECOV, RST_DISARM_RECOV,
                     RST_STICK_LIMIT, RST_STICK_CENTRE, RST_GOOD_BEEP, RST_ALARM_BEEP};
        loss_cnt = '0;
        fast_flag = 1'b0;
        event_flag = 1'b0;
        good_beep_pend = 1'b0;
        disarm_done = 1'b0;
        good_ticks = '0;
        beep_ticks = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: field extremes, then a loss run that sets the sticky fast flag only.
        gap_pct = 20;
        stall_pct = 20;
        queue_fixed(1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0);
        queue_fixed(1'b1, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
        for (i = 0; i < 14; i++)
            queue_fixed(1'b0, 1'(i), (i % 2) ? 12'hFFF : 12'd0, 12'd1500, 12'd1500,
                        1'(i / 2), 1'b0);
        wait_idle();

        // Short limits: armed event held by centred sticks, released by motion, link-good
        // beep, then a disarmed event that clears with the return-to-home switch on.
        c = '{10'd1, 10'd3, 10'd2, 10'd1, 14'd40, 12'd1500, 8'd1, 8'd2};
        load_settings(c);
        repeat (4) queue_fixed(1'b0, 1'b1, 12'd1500, 12'd1500, 12'd1500, 1'b0, 1'b0);
        repeat (2) queue_fixed(1'b1, 1'b1, 12'd1500, 12'd1500, 12'd1500, 1'b0, 1'b0);
        queue_fixed(1'b1, 1'b1, 12'd1550, 12'd1500, 12'd1500, 1'b0, 1'b0);
        repeat (2) queue_fixed(1'b1, 1'b1, 12'd1500, 12'd1500, 12'd1500, 1'b0, 1'b0);
        repeat (4) queue_fixed(1'b0, 1'b0, 12'd1500, 12'd1500, 12'd1500, 1'b1, 1'b1);
        repeat (2) queue_fixed(1'b1, 1'b0, 12'd1500, 12'd1500, 12'd1500, 1'b1, 1'b0);

        run_phase('0, 40, 1'b0);

        // Largest settings with an unreachable stick limit: short loss runs stay below
        // every limit.
        wait_idle();
        c = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 14'h3FFF, 12'hFFF, 8'd255, 8'd255};
        load_settings(c);
        gap_pct = 0;
        stall_pct = 0;
        for (i = 0; i < MAX_RUN; i++) pending_ticks.push_back(make_tick(1'b0, 1'b1, 4095));
        for (i = 0; i < MAX_RUN; i++) pending_ticks.push_back(make_tick(1'b1, 1'(i % 2), 4095));

        for (i = 0; i < 8; i++) run_phase(random_settings(), 30, i == 2);

        wait_idle();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (expected_flags.size() != 0) n_mismatch++;
        $display("%0d ticks over %0d register settings, loss counter saturated on %0d ticks",
                 n_ticks, n_settings, n_saturated);
        $display("%0d forced, %0d recoveries (%0d releasing RTH), %0d good beeps, %0d alarms",
                 n_forced, n_recovered, n_released, n_good_beeps, n_alarms);
        if (n_mismatch == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/rclf_pkg.sv
hw/rtl/rclf_cfg_regs.sv
hw/rtl/rclf_tick_engine.sv
hw/rtl/rc_link_failsafe_monitor.sv
bench/testbench.sv
